@@ src/ppj_pkg.sv @@
// Shared constants, types and helper functions of the homogeneous point projector.
package ppj_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 10;

  localparam int CW        = 32;
  localparam int KW        = 21;
  localparam int REG_W     = 63;
  localparam int IDX_W     = 3;
  localparam int SCR_W     = 32;
  localparam int TW_W      = 16;
  localparam int FULL_FRAC = COORD_FRAC_BITS + COEF_FRAC_BITS;

  localparam int PW    = KW + CW;
  localparam int ACC_W = PW + 2;
  localparam int MAG_W = ACC_W - 1;
  localparam int QB    = SCR_W + 1;

  localparam int DW  = ((KW + COORD_FRAC_BITS) > (CW + COEF_FRAC_BITS) ?
                        (KW + COORD_FRAC_BITS) : (CW + COEF_FRAC_BITS)) + 2;
  localparam int DMW = DW - 1;

  localparam int SQ_W      = 30;
  localparam int SHW       = $clog2(DMW - SQ_W + 1);
  localparam int SSW       = 2 * SQ_W + 2;
  localparam int SQ_STEPS  = SSW / 2;
  localparam int SQ_ROOT_W = SQ_STEPS;
  localparam int SQR_W     = SQ_ROOT_W + 2;

  localparam int UNIT_SH  = 14;
  localparam int UNIT_Q14 = 1 << UNIT_SH;
  localparam int TQB      = UNIT_SH + 1;
  localparam int TN_W     = SQ_W + UNIT_SH + 1;

  localparam int NSTEP = (QB > SQ_STEPS + 1 + TQB) ? QB : SQ_STEPS + 1 + TQB;

  localparam longint unsigned EPS_RAW =
    ((64'd1 << FULL_FRAC) + 64'd500000) / 64'd1000000;
  localparam longint unsigned EPS = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;
  localparam longint unsigned DIR_RAW =
    ((64'd1 << FULL_FRAC) + 64'd5000) / 64'd10000;
  localparam longint unsigned DIR_LIM = (DIR_RAW == 0) ? 64'd1 : DIR_RAW;
  localparam longint unsigned EPS_SQ  = EPS * EPS;

  localparam int VSH_L = (COEF_FRAC_BITS <= UNIT_SH) ? UNIT_SH - COEF_FRAC_BITS : 0;
  localparam int VSH_R = (COEF_FRAC_BITS > UNIT_SH) ? COEF_FRAC_BITS - UNIT_SH : 0;
  localparam int VRND  = (COEF_FRAC_BITS > UNIT_SH) ? (1 << (VSH_R - 1)) : 0;
  localparam int VMW   = KW + UNIT_SH + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_W,
    REG_TRANS,
    REG_EYE,
    REG_VIEW,
    REG_PERSP
  } reg_idx_t;

  typedef struct packed {
    logic                           dir;
    logic                           res_valid;
    logic                           neg_x;
    logic                           neg_y;
    logic                           sat_x;
    logic                           sat_y;
    logic [MAG_W-1:0]               den;
    logic [MAG_W-1:0]               rx;
    logic [MAG_W-1:0]               ry;
    logic [QB-1:0]                  qx;
    logic [QB-1:0]                  qy;
    logic                           fallback;
    logic [2:0]                     tw_neg;
    logic [2:0][SQ_W-1:0]           dm;
    logic [SSW-1:0]                 sq_in;
    logic [SQR_W-1:0]               sq_rem;
    logic [SQ_ROOT_W-1:0]           sq_root;
    logic [2:0][SQ_ROOT_W-1:0]      trem;
    logic [2:0][TQB-1:0]            tq;
  } work_t;

  function automatic logic signed [KW-1:0] coef_field(input logic [REG_W-1:0] r,
                                                      input int unsigned i);
    coef_field = r[KW*i +: KW];
  endfunction

  function automatic logic signed [TW_W-1:0] view_q14(input logic signed [KW-1:0] v);
    logic [KW-1:0]  m;
    logic [VMW-1:0] mw;
    logic [TW_W-1:0] t;
    m  = (v < 0) ? KW'(-v) : KW'(v);
    mw = ((VMW'(m) << VSH_L) + VMW'(VRND)) >> VSH_R;
    t  = (mw > VMW'(UNIT_Q14)) ? TW_W'(UNIT_Q14) : TW_W'(mw);
    view_q14 = (v < 0) ? -$signed(t) : $signed(t);
  endfunction

endpackage

@@ src/ppj_cell.sv @@
// One cell of the projector chain: division, square-root and unit-vector steps.
module ppj_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_in,
  input  ppj_pkg::work_t d,
  output logic           vld_out,
  output ppj_pkg::work_t q
);

  ppj_pkg::work_t w;

  always_comb begin
    logic [ppj_pkg::MAG_W:0]       trx;
    logic [ppj_pkg::MAG_W:0]       try_y;
    logic [ppj_pkg::SQR_W+1:0]     st;
    logic [ppj_pkg::SQR_W+1:0]     strial;
    logic [ppj_pkg::SQ_ROOT_W:0]   tt;
    logic [ppj_pkg::TN_W-1:0]      tn;
    logic [ppj_pkg::SQ_ROOT_W-1:0] len;
    trx    = '0;
    try_y  = '0;
    st     = '0;
    strial = '0;
    tt     = '0;
    tn     = '0;
    len    = '0;
    w      = d;
    if (STEP < ppj_pkg::QB) begin
      trx   = {d.rx, d.qx[ppj_pkg::QB-1]};
      try_y = {d.ry, d.qy[ppj_pkg::QB-1]};
      if (trx >= {1'b0, d.den}) begin
        w.rx = ppj_pkg::MAG_W'(trx - {1'b0, d.den});
        w.qx = {d.qx[ppj_pkg::QB-2:0], 1'b1};
      end else begin
        w.rx = trx[ppj_pkg::MAG_W-1:0];
        w.qx = {d.qx[ppj_pkg::QB-2:0], 1'b0};
      end
      if (try_y >= {1'b0, d.den}) begin
        w.ry = ppj_pkg::MAG_W'(try_y - {1'b0, d.den});
        w.qy = {d.qy[ppj_pkg::QB-2:0], 1'b1};
      end else begin
        w.ry = try_y[ppj_pkg::MAG_W-1:0];
        w.qy = {d.qy[ppj_pkg::QB-2:0], 1'b0};
      end
    end
    if (STEP < ppj_pkg::SQ_STEPS) begin
      st     = {d.sq_rem, d.sq_in[ppj_pkg::SSW-1 -: 2]};
      strial = (ppj_pkg::SQR_W+2)'({d.sq_root, 2'b01});
      if (st >= strial) begin
        w.sq_rem  = ppj_pkg::SQR_W'(st - strial);
        w.sq_root = {d.sq_root[ppj_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        w.sq_rem  = st[ppj_pkg::SQR_W-1:0];
        w.sq_root = {d.sq_root[ppj_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
      w.sq_in = d.sq_in << 2;
    end
    if (STEP == ppj_pkg::SQ_STEPS) begin
      len = (d.sq_root == '0) ? ppj_pkg::SQ_ROOT_W'(1) : d.sq_root;
      w.sq_root = len;
      for (int i = 0; i < 3; i++) begin
        tn = {1'b0, d.dm[i], {ppj_pkg::UNIT_SH{1'b0}}} + ppj_pkg::TN_W'(len >> 1);
        w.trem[i] = ppj_pkg::SQ_ROOT_W'(tn >> ppj_pkg::TQB);
        w.tq[i]   = tn[ppj_pkg::TQB-1:0];
      end
    end
    if (STEP > ppj_pkg::SQ_STEPS && STEP <= ppj_pkg::SQ_STEPS + ppj_pkg::TQB) begin
      for (int i = 0; i < 3; i++) begin
        tt = {d.trem[i], d.tq[i][ppj_pkg::TQB-1]};
        if (tt >= {1'b0, d.sq_root}) begin
          w.trem[i] = ppj_pkg::SQ_ROOT_W'(tt - {1'b0, d.sq_root});
          w.tq[i]   = {d.tq[i][ppj_pkg::TQB-2:0], 1'b1};
        end else begin
          w.trem[i] = tt[ppj_pkg::SQ_ROOT_W-1:0];
          w.tq[i]   = {d.tq[i][ppj_pkg::TQB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= w;
    end
  end

endmodule

@@ src/ppj_front.sv @@
// Front stages of the projector: matrix products, row sums, divider setup and squared length.
module ppj_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic                        kind,
  input  logic signed [ppj_pkg::CW-1:0] coord_x,
  input  logic signed [ppj_pkg::CW-1:0] coord_y,
  input  logic signed [ppj_pkg::CW-1:0] coord_z,
  input  logic [ppj_pkg::REG_W-1:0]   row_x,
  input  logic [ppj_pkg::REG_W-1:0]   row_y,
  input  logic [ppj_pkg::REG_W-1:0]   row_w,
  input  logic [ppj_pkg::REG_W-1:0]   trans,
  input  logic [ppj_pkg::REG_W-1:0]   eye,
  input  logic                        persp,
  output logic                        vld_out,
  output ppj_pkg::work_t              q
);

  localparam int TRW = ppj_pkg::KW + ppj_pkg::COORD_FRAC_BITS;

  logic [ppj_pkg::REG_W-1:0]          rows [3];
  logic signed [ppj_pkg::CW-1:0]      p [3];

  logic                               v1, dir1;
  logic signed [ppj_pkg::PW-1:0]      prod1 [3][3];
  logic signed [TRW-1:0]              trans1 [3];
  logic signed [ppj_pkg::DW-1:0]      d1 [3];

  logic                               v2, dir2;
  logic signed [ppj_pkg::ACC_W-1:0]   acc2 [3];
  logic [ppj_pkg::DMW-1:0]            dm2 [3];
  logic [2:0]                         dneg2;

  logic                               v3, sh3, sh3_next;
  ppj_pkg::work_t                     w3, w3_next;
  logic                               v4, sh4;
  ppj_pkg::work_t                     w4;
  logic [2*ppj_pkg::SQ_W-1:0]         sq4 [3];
  ppj_pkg::work_t                     q_next;

  logic signed [ppj_pkg::DW-1:0]      d1_next [3];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_w;
  assign p[0]    = coord_x;
  assign p[1]    = coord_y;
  assign p[2]    = coord_z;

  always_comb begin
    logic signed [TRW-1:0]                               ce;
    logic signed [ppj_pkg::CW+ppj_pkg::COEF_FRAC_BITS-1:0] pe;
    for (int i = 0; i < 3; i++) begin
      ce = {ppj_pkg::coef_field(eye, i), {ppj_pkg::COORD_FRAC_BITS{1'b0}}};
      pe = {p[i], {ppj_pkg::COEF_FRAC_BITS{1'b0}}};
      d1_next[i] = ppj_pkg::DW'(ce) - ppj_pkg::DW'(pe);
    end
  end

  always_comb begin
    logic [ppj_pkg::MAG_W-1:0] ax, ay, aw;
    logic                      wbig, wneg;
    logic [ppj_pkg::DMW-1:0]   ord;
    logic [ppj_pkg::SHW-1:0]   s;
    ax   = ppj_pkg::MAG_W'((acc2[0] < 0) ? -acc2[0] : acc2[0]);
    ay   = ppj_pkg::MAG_W'((acc2[1] < 0) ? -acc2[1] : acc2[1]);
    aw   = ppj_pkg::MAG_W'((acc2[2] < 0) ? -acc2[2] : acc2[2]);
    wbig = aw > ppj_pkg::MAG_W'(ppj_pkg::EPS);
    wneg = (dir2 | wbig) & acc2[2][ppj_pkg::ACC_W-1];
    ord  = dm2[0] | dm2[1] | dm2[2];
    s    = '0;
    for (int k = 1; k <= ppj_pkg::DMW - ppj_pkg::SQ_W; k++) begin
      if ((ord >> (ppj_pkg::SQ_W + k - 1)) != '0) begin
        s = ppj_pkg::SHW'(k);
      end
    end
    w3_next           = '0;
    w3_next.dir       = dir2;
    w3_next.den       = (dir2 | wbig) ? aw : ppj_pkg::MAG_W'(ppj_pkg::EPS);
    w3_next.res_valid = dir2 ? (persp & (aw >= ppj_pkg::MAG_W'(ppj_pkg::DIR_LIM))) : 1'b1;
    w3_next.neg_x     = acc2[0][ppj_pkg::ACC_W-1] ^ wneg;
    w3_next.neg_y     = ~(acc2[1][ppj_pkg::ACC_W-1] ^ wneg);
    w3_next.rx        = ax >> (ppj_pkg::QB - ppj_pkg::COORD_FRAC_BITS);
    w3_next.ry        = ay >> (ppj_pkg::QB - ppj_pkg::COORD_FRAC_BITS);
    w3_next.qx        = {ax[ppj_pkg::QB-ppj_pkg::COORD_FRAC_BITS-1:0],
                         {ppj_pkg::COORD_FRAC_BITS{1'b0}}};
    w3_next.qy        = {ay[ppj_pkg::QB-ppj_pkg::COORD_FRAC_BITS-1:0],
                         {ppj_pkg::COORD_FRAC_BITS{1'b0}}};
    w3_next.sat_x     = w3_next.rx >= w3_next.den;
    w3_next.sat_y     = w3_next.ry >= w3_next.den;
    w3_next.tw_neg    = dneg2;
    for (int i = 0; i < 3; i++) begin
      w3_next.dm[i] = ppj_pkg::SQ_W'(dm2[i] >> s);
    end
    sh3_next = (s != '0);
  end

  always_comb begin
    logic [ppj_pkg::SSW-1:0] ss;
    ss = ppj_pkg::SSW'(sq4[0]) + ppj_pkg::SSW'(sq4[1]) + ppj_pkg::SSW'(sq4[2]);
    q_next          = w4;
    q_next.sq_in    = ss;
    q_next.fallback = ~persp | (~sh4 & (ss <= ppj_pkg::SSW'(ppj_pkg::EPS_SQ)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      vld_out <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir1 <= kind;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod1[r][i] <= ppj_pkg::coef_field(rows[r], i) * p[i];
        end
        trans1[r] <= kind ? '0 :
                     {ppj_pkg::coef_field(trans, r), {ppj_pkg::COORD_FRAC_BITS{1'b0}}};
        d1[r]     <= d1_next[r];
      end

      dir2 <= dir1;
      for (int r = 0; r < 3; r++) begin
        acc2[r]  <= ppj_pkg::ACC_W'(prod1[r][0]) + ppj_pkg::ACC_W'(prod1[r][1])
                  + ppj_pkg::ACC_W'(prod1[r][2]) + ppj_pkg::ACC_W'(trans1[r]);
        dm2[r]   <= ppj_pkg::DMW'((d1[r] < 0) ? -d1[r] : d1[r]);
        dneg2[r] <= d1[r][ppj_pkg::DW-1];
      end

      w3  <= w3_next;
      sh3 <= sh3_next;

      w4  <= w3;
      sh4 <= sh3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= (2*ppj_pkg::SQ_W)'(w3.dm[i]) * (2*ppj_pkg::SQ_W)'(w3.dm[i]);
      end

      q <= q_next;
    end
  end

endmodule

@@ src/homogeneous_point_projector.sv @@
// Top level of the homogeneous point projector: configuration registers, cell chain and output.
// The block takes one point or direction beat per clock unless out_stall holds a valid output,
// and gives one result beat per input beat, in order: five front stages for the matrix
// products, row sums and squared eye distance, a chain of 47 cells for the screen-coordinate
// divisions, eye-distance square root and unit-vector divisions, and one output register.
// Configuration writes take effect at once and must be made while no beat is in flight.
module homogeneous_point_projector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic signed [ppj_pkg::CW-1:0]     coord_x,
  input  logic signed [ppj_pkg::CW-1:0]     coord_y,
  input  logic signed [ppj_pkg::CW-1:0]     coord_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ppj_pkg::SCR_W-1:0]  screen_x,
  output logic signed [ppj_pkg::SCR_W-1:0]  screen_y,
  output logic                              valid_res,
  output logic signed [ppj_pkg::TW_W-1:0]   toward_x,
  output logic signed [ppj_pkg::TW_W-1:0]   toward_y,
  output logic signed [ppj_pkg::TW_W-1:0]   toward_z,
  input  logic                              write_en,
  input  logic [ppj_pkg::IDX_W-1:0]         write_index,
  input  logic [ppj_pkg::REG_W-1:0]         write_data
);

  logic [ppj_pkg::REG_W-1:0] row_x, row_y, row_w, trans, eye, view;
  logic                      persp;
  logic                      en;

  logic                      cv [ppj_pkg::NSTEP+1];
  ppj_pkg::work_t            cw [ppj_pkg::NSTEP+1];
  ppj_pkg::work_t            fin;

  logic signed [ppj_pkg::SCR_W-1:0] sx_next, sy_next;
  logic signed [ppj_pkg::TW_W-1:0]  tw_next [3];

  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= '0;
      row_y <= '0;
      row_w <= '0;
      trans <= '0;
      eye   <= '0;
      view  <= '0;
      persp <= 1'b0;
    end else if (write_en) begin
      case (ppj_pkg::reg_idx_t'(write_index))
        ppj_pkg::REG_ROW_X: row_x <= write_data;
        ppj_pkg::REG_ROW_Y: row_y <= write_data;
        ppj_pkg::REG_ROW_W: row_w <= write_data;
        ppj_pkg::REG_TRANS: trans <= write_data;
        ppj_pkg::REG_EYE:   eye   <= write_data;
        ppj_pkg::REG_VIEW:  view  <= write_data;
        ppj_pkg::REG_PERSP: persp <= write_data[0];
        default: ;
      endcase
    end
  end

  ppj_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .kind    (kind),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .row_x   (row_x),
    .row_y   (row_y),
    .row_w   (row_w),
    .trans   (trans),
    .eye     (eye),
    .persp   (persp),
    .vld_out (cv[0]),
    .q       (cw[0])
  );

  for (genvar k = 0; k < ppj_pkg::NSTEP; k++) begin : g_chain
    ppj_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (cv[k]),
      .d       (cw[k]),
      .vld_out (cv[k+1]),
      .q       (cw[k+1])
    );
  end

  assign fin = cw[ppj_pkg::NSTEP];

  function automatic logic signed [ppj_pkg::SCR_W-1:0] sat_quot(
      input logic [ppj_pkg::QB-1:0] qv, input logic sat, input logic neg);
    logic [ppj_pkg::QB-1:0] lim;
    logic [ppj_pkg::QB-1:0] m;
    lim = ppj_pkg::QB'(64'd1 << (ppj_pkg::SCR_W - 1));
    m   = (sat | (qv > lim)) ? lim : qv;
    if (neg) begin
      sat_quot = ppj_pkg::SCR_W'(-m);
    end else begin
      sat_quot = (m > lim - 1'b1) ? ppj_pkg::SCR_W'(lim - 1'b1) : ppj_pkg::SCR_W'(m);
    end
  endfunction

  always_comb begin
    logic [ppj_pkg::TQB-1:0] t;
    sx_next = fin.res_valid ? sat_quot(fin.qx, fin.sat_x, fin.neg_x) : '0;
    sy_next = fin.res_valid ? sat_quot(fin.qy, fin.sat_y, fin.neg_y) : '0;
    for (int i = 0; i < 3; i++) begin
      t = (fin.tq[i] > ppj_pkg::TQB'(ppj_pkg::UNIT_Q14)) ?
          ppj_pkg::TQB'(ppj_pkg::UNIT_Q14) : fin.tq[i];
      if (fin.dir) begin
        tw_next[i] = '0;
      end else if (fin.fallback) begin
        tw_next[i] = ppj_pkg::view_q14(ppj_pkg::coef_field(view, i));
      end else if (fin.tw_neg[i]) begin
        tw_next[i] = -$signed(ppj_pkg::TW_W'(t));
      end else begin
        tw_next[i] = $signed(ppj_pkg::TW_W'(t));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[ppj_pkg::NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en && cv[ppj_pkg::NSTEP]) begin
      screen_x  <= sx_next;
      screen_y  <= sy_next;
      valid_res <= fin.res_valid;
      toward_x  <= tw_next[0];
      toward_y  <= tw_next[1];
      toward_z  <= tw_next[2];
    end
  end

endmodule
